FILE: rtl/core/nfa_word_acceptor_defines.svh
// Assertion macros for the NFA word acceptor.
`ifndef NFA_WORD_ACCEPTOR_DEFINES_SVH
`define NFA_WORD_ACCEPTOR_DEFINES_SVH

`ifndef SYNTH
`define NWA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nwa assertion failed");
`define NWA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nwa assertion failed");
`define NWA_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("nwa assertion failed");
`else
`define NWA_ASSERT_IMPL(lbl, ante, cons)
`define NWA_ASSERT_NEXT(lbl, ante, cons)
`define NWA_ASSERT_ALWAYS(lbl, cond)
`endif

`endif

FILE: rtl/core/nwa_pkg.sv
package nwa_pkg;

  localparam int MODE_W  = 3;
  localparam int ENTRY_W = 6;
  localparam int STATE_W = 4;
  localparam int SYM_W   = 8;
  localparam int CNT_W   = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_FLAGS  = 3'd0,
    MODE_WRITE  = 3'd1,
    MODE_BEGIN  = 3'd2,
    MODE_SYMBOL = 3'd3,
    MODE_END    = 3'd4
  } nwa_mode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } nwa_state_t;

  // transition write, broadcast to the cells with a per-cell enable
  typedef struct packed {
    logic               en;
    logic [STATE_W-1:0] from_st;
    logic [STATE_W-1:0] to_st;
    logic [SYM_W-1:0]   tag;
  } nwa_wr_t;

endpackage

FILE: rtl/core/nwa_cell.sv
module nwa_cell #(
  parameter int NUM_STATES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nwa_pkg::nwa_wr_t      wr,
  input  logic                  in_use,
  input  logic [7:0]            sym,
  input  logic [NUM_STATES-1:0] set,
  input  logic                  tok_v_i,
  input  logic [NUM_STATES-1:0] tok_acc_i,
  output logic                  tok_v_o,
  output logic [NUM_STATES-1:0] tok_acc_o
);
  import nwa_pkg::*;

  localparam logic [NUM_STATES-1:0] BIT0 = {{(NUM_STATES-1){1'b0}}, 1'b1};

  logic [STATE_W-1:0]    from_r;
  logic [STATE_W-1:0]    to_r;
  logic [SYM_W-1:0]      tag_r;
  logic                  tok_v_r;
  logic [NUM_STATES-1:0] tok_acc_r;
  logic                  src_hit;
  logic                  fire;
  logic [NUM_STATES-1:0] to_bit;

  // shifts past the set width give zero: such states never fire or land
  assign src_hit = |(set & (BIT0 << from_r));
  assign to_bit  = BIT0 << to_r;
  assign fire    = tok_v_i & in_use & src_hit & (tag_r == sym);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      from_r <= wr.from_st;
      to_r   <= wr.to_st;
      tag_r  <= wr.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_v_r <= 1'b0;
    end else begin
      tok_v_r <= tok_v_i;
    end
  end

  always_ff @(posedge clk) begin
    tok_acc_r <= fire ? (tok_acc_i | to_bit) : tok_acc_i;
  end

  assign tok_v_o   = tok_v_r;
  assign tok_acc_o = tok_acc_r;

endmodule

FILE: rtl/core/nfa_word_acceptor.sv
// channel | direction | handshake             | payload
// in_     | to block  | in_valid / in_stall   | mode, entry, state_id, flags, from/to, symbol
// out_    | from block| out_valid / out_stall | accepted, alive
// cfg_    | to block  | cfg_we                | cfg_wdata = transitions_in_use
//
// A symbol word sends a token down the cell row, one transition entry per cell per
// cycle. All other words give their result without a walk of the row.
// One result can wait behind a stalled output register; a further word stalls.
// Reset (rst_n low, synchronous) clears flags, active set and count; the
// transition entries in the cells hold no reset value.
`include "nfa_word_acceptor_defines.svh"

module nfa_word_acceptor #(
  parameter int NUM_STATES      = 16,
  parameter int NUM_TRANSITIONS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [nwa_pkg::MODE_W-1:0]  in_mode,
  input  logic [nwa_pkg::ENTRY_W-1:0] in_entry,
  input  logic [nwa_pkg::STATE_W-1:0] in_state_id,
  input  logic                        in_is_start,
  input  logic                        in_is_final,
  input  logic [nwa_pkg::STATE_W-1:0] in_from_state,
  input  logic [nwa_pkg::STATE_W-1:0] in_to_state,
  input  logic [nwa_pkg::SYM_W-1:0]   in_symbol,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_accepted,
  output logic                        out_alive,
  input  logic                        cfg_we,
  input  logic [nwa_pkg::CNT_W-1:0]   cfg_wdata
);
  import nwa_pkg::*;

  localparam int NS = NUM_STATES;
  localparam int NT = NUM_TRANSITIONS;
  localparam logic [NS-1:0] BIT0 = {{(NS-1){1'b0}}, 1'b1};

  nwa_state_t            state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic [NS-1:0]         start_r, start_nxt;
  logic [NS-1:0]         final_r, final_nxt;
  logic [NS-1:0]         active_r, active_nxt;
  logic [SYM_W-1:0]      sym_r;
  logic                  kick_r;
  logic                  pend_r, pend_nxt;
  logic                  pend_acc_r, pend_alive_r;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_acc_r, out_alive_r;

  logic                  in_acc;
  logic                  launch;
  logic                  done;
  logic                  imm_v, imm_acc, imm_alive;
  logic                  res_v, res_acc, res_alive;
  logic                  out_free;
  logic [NS-1:0]         sid_bit;
  logic [NS-1:0]         scan_set;

  logic [NT-1:0]         tok_v;
  logic [NS-1:0]         tok_acc [NT];
  logic [NT-1:0]         use_v;
  logic [NT-1:0]         wr_hit;
  logic                  wr_go;

  assign in_acc  = in_valid & ~in_stall;
  assign launch  = in_acc & (in_mode == MODE_SYMBOL);
  assign wr_go   = in_acc & (in_mode == MODE_WRITE);
  assign done    = tok_v[NT-1];
  assign sid_bit = BIT0 << in_state_id;
  assign scan_set = tok_acc[NT-1];

  // cell row
  genvar g;
  generate
    for (g = 0; g < NT; g++) begin : g_cell
      nwa_wr_t wr_c;
      assign use_v[g]     = int'(cnt_r) > g;
      assign wr_hit[g]    = int'(in_entry) == g;
      assign wr_c.en      = wr_go & wr_hit[g];
      assign wr_c.from_st = in_from_state;
      assign wr_c.to_st   = in_to_state;
      assign wr_c.tag     = in_symbol;
      if (g == 0) begin : g_head
        nwa_cell #(.NUM_STATES(NS)) u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .wr        (wr_c),
          .in_use    (use_v[g]),
          .sym       (sym_r),
          .set       (active_r),
          .tok_v_i   (kick_r),
          .tok_acc_i ({NS{1'b0}}),
          .tok_v_o   (tok_v[g]),
          .tok_acc_o (tok_acc[g])
        );
      end else begin : g_body
        nwa_cell #(.NUM_STATES(NS)) u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .wr        (wr_c),
          .in_use    (use_v[g]),
          .sym       (sym_r),
          .set       (active_r),
          .tok_v_i   (tok_v[g-1]),
          .tok_acc_i (tok_acc[g-1]),
          .tok_v_o   (tok_v[g]),
          .tok_acc_o (tok_acc[g])
        );
      end
    end
  endgenerate

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (launch) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    unique case (state_r)
      ST_IDLE: in_stall = pend_r;
      ST_SCAN: in_stall = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  // word decode
  always_comb begin
    start_nxt  = start_r;
    final_nxt  = final_r;
    active_nxt = active_r;
    imm_v      = 1'b0;
    imm_acc    = 1'b0;
    imm_alive  = |active_r;
    if (done) begin
      active_nxt = scan_set;
    end
    if (in_acc) begin
      unique case (in_mode)
        MODE_FLAGS: begin
          imm_v     = 1'b1;
          start_nxt = in_is_start ? (start_r | sid_bit) : (start_r & ~sid_bit);
          final_nxt = in_is_final ? (final_r | sid_bit) : (final_r & ~sid_bit);
        end
        MODE_WRITE: imm_v = 1'b1;
        MODE_BEGIN: begin
          imm_v      = 1'b1;
          active_nxt = start_r;
          imm_alive  = |start_r;
        end
        MODE_SYMBOL: imm_v = 1'b0;
        MODE_END: begin
          imm_v   = 1'b1;
          imm_acc = |(active_r & final_r);
        end
        default: imm_v = 1'b1;
      endcase
    end
  end

  assign res_v     = imm_v | done;
  assign res_acc   = done ? 1'b0 : imm_acc;
  assign res_alive = done ? |scan_set : imm_alive;
  assign out_free  = ~out_valid_r | ~out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    pend_nxt      = pend_r;
    if (out_free) begin
      out_valid_nxt = pend_r | res_v;
      pend_nxt      = 1'b0;
    end else if (res_v) begin
      pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      start_r     <= '0;
      final_r     <= '0;
      active_r    <= '0;
      kick_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      final_r     <= final_nxt;
      active_r    <= active_nxt;
      kick_r      <= launch;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) cnt_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (launch) sym_r <= in_symbol;
    if (out_free) begin
      out_acc_r   <= pend_r ? pend_acc_r : res_acc;
      out_alive_r <= pend_r ? pend_alive_r : res_alive;
    end else if (res_v) begin
      pend_acc_r   <= res_acc;
      pend_alive_r <= res_alive;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_accepted = out_acc_r;
  assign out_alive    = out_alive_r;

  `NWA_ASSERT_IMPL(a_pend_behind_out, pend_r, out_valid_r)
  `NWA_ASSERT_IMPL(a_done_in_scan, done, state_r == ST_SCAN)
  `NWA_ASSERT_ALWAYS(a_one_token, $onehot0({kick_r, tok_v}))
  `NWA_ASSERT_IMPL(a_acc_alive, out_valid_r && out_acc_r, out_alive_r)
  `NWA_ASSERT_NEXT(a_launch_kick, launch, kick_r && state_r == ST_SCAN)

endmodule
